// File: hdl/mbcr_pkg.sv
// ----------------------------------------------------------------------------
// Mesh box crop package
// Shared types, sizes and codes for the mesh box crop core and its channels.
// ----------------------------------------------------------------------------
package mbcr_pkg;

  // Point store depth and derived widths
  localparam int MAX_POINTS = 65536;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int VIDX_W     = 16;
  localparam int CMP_W      = (CNT_W > VIDX_W) ? CNT_W : VIDX_W;
  localparam int COORD_W    = 32;
  localparam int NUM_REGS   = 6;
  localparam int REG_IDX_W  = 3;

  // Item function codes
  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_TRI   = 2'd1;
  localparam logic [1:0] FUNC_NEW   = 2'd2;

  // Result kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_TRI   = 1'b1;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_Z = 3'd5;

  // Input word
  typedef struct packed {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [VIDX_W-1:0]         vertex_a;
    logic [VIDX_W-1:0]         vertex_b;
    logic [VIDX_W-1:0]         vertex_c;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [VIDX_W-1:0]         new_index;
    logic [VIDX_W-1:0]         out_vertex_a;
    logic [VIDX_W-1:0]         out_vertex_b;
    logic [VIDX_W-1:0]         out_vertex_c;
  } out_word_t;

  // Point store entry
  typedef struct packed {
    logic              keep;
    logic [VIDX_W-1:0] remap;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PNT,
    S_PWR,
    S_TRI,
    S_TLAST,
    S_EMIT
  } state_t;

  // Vertex index to store address
  function automatic logic [ADDR_W-1:0] vidx_to_addr(input logic [VIDX_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return w[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/mbcr_ifs.sv
// ----------------------------------------------------------------------------
// Mesh box crop channels
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface mbcr_in_if import mbcr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mbcr_out_if import mbcr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/mesh_box_crop_with_remap_core.sv
// ----------------------------------------------------------------------------
// Mesh box crop core
// Crops a streamed triangle mesh to an axis-aligned box and compacts indices.
// ----------------------------------------------------------------------------
// One word is worked on at a time and the input is not ready meanwhile. A
// kept point or triangle word holds ready low until its result is loaded,
// which waits while the result register is still waiting to be taken; a
// new-mesh word, an unused code and a point arriving with the store full
// leave the input ready, and a dropped point or triangle returns to ready
// without a result. Points pass one axis a cycle through a single pair of
// signed comparators; triangles read the keep/remap store three times through
// its one registered read port. The store needs no clearing after reset: only
// entries loaded since the last new-mesh word ever affect a result.
module mesh_box_crop_with_remap_core import mbcr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  mbcr_in_if.sink              item,
  mbcr_out_if.source           result,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  // Box bounds, one per axis
  logic signed [COORD_W-1:0] box_min [3];
  logic signed [COORD_W-1:0] box_max [3];

  state_t            state, state_next;
  in_word_t          item_q;
  logic              kind_q;
  logic [1:0]        step;
  logic              ok;
  logic [CNT_W-1:0]  points_loaded;
  logic [CNT_W-1:0]  points_kept;
  logic [VIDX_W-1:0] new_idx_q;
  logic [VIDX_W-1:0] remap_q [3];
  logic              out_valid_q;
  out_word_t         out_q;

  // Point store
  entry_t            mem [MAX_POINTS];
  entry_t            rd_q;
  entry_t            wr_ent;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_we;
  logic              ld_out;

  logic                      store_full;
  logic signed [COORD_W-1:0] coord_sel;
  logic                      axis_in;
  logic [VIDX_W-1:0]         vtx_sel;
  logic                      vtx_in;
  logic                      tri_ok;

  assign store_full = (points_loaded == CNT_W'(MAX_POINTS));

  // Shared axis compare
  always_comb begin
    unique case (step)
      2'd0:    coord_sel = item_q.point_x;
      2'd1:    coord_sel = item_q.point_y;
      default: coord_sel = item_q.point_z;
    endcase
  end

  assign axis_in = (coord_sel >= box_min[step]) && (coord_sel <= box_max[step]);

  // Vertex select, range check and store address
  always_comb begin
    unique case (step)
      2'd0:    vtx_sel = item_q.vertex_a;
      2'd1:    vtx_sel = item_q.vertex_b;
      default: vtx_sel = item_q.vertex_c;
    endcase
  end

  assign vtx_in  = (CMP_W'(vtx_sel) < CMP_W'(points_loaded));
  assign rd_addr = vidx_to_addr(vtx_sel);
  assign tri_ok  = ok && rd_q.keep;

  assign wr_addr      = points_loaded[ADDR_W-1:0];
  assign wr_ent.keep  = ok;
  assign wr_ent.remap = ok ? VIDX_W'(points_kept) : '0;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    mem_we     = 1'b0;
    ld_out     = 1'b0;
    unique case (state)
      S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          if (item.data.func == FUNC_POINT && !store_full) begin
            state_next = S_PNT;
          end else if (item.data.func == FUNC_TRI) begin
            state_next = S_TRI;
          end
        end
      end
      S_PNT: begin
        if (step == 2'd2) begin
          state_next = S_PWR;
        end
      end
      S_PWR: begin
        mem_we     = 1'b1;
        state_next = ok ? S_EMIT : S_IDLE;
      end
      S_TRI: begin
        if (step == 2'd2) begin
          state_next = S_TLAST;
        end
      end
      S_TLAST: begin
        state_next = tri_ok ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_q || result.ready) begin
          ld_out     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_min[i] <= '0;
        box_max[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: box_min[0] <= cfg_data;
        REG_MIN_Y: box_min[1] <= cfg_data;
        REG_MIN_Z: box_min[2] <= cfg_data;
        REG_MAX_X: box_max[0] <= cfg_data;
        REG_MAX_Y: box_max[1] <= cfg_data;
        REG_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      points_loaded <= '0;
      points_kept   <= '0;
    end else if (state == S_IDLE && item.valid && item.data.func == FUNC_NEW) begin
      points_loaded <= '0;
      points_kept   <= '0;
    end else if (state == S_PWR) begin
      points_loaded <= points_loaded + 1'b1;
      if (ok) begin
        points_kept <= points_kept + 1'b1;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        item_q <= item.data;
        kind_q <= (item.data.func == FUNC_TRI) ? KIND_TRI : KIND_POINT;
        step   <= 2'd0;
        ok     <= 1'b1;
      end
      S_PNT: begin
        ok   <= ok && axis_in;
        step <= step + 2'd1;
      end
      S_PWR: begin
        new_idx_q <= VIDX_W'(points_kept);
      end
      S_TRI: begin
        // read data for the previous vertex lands this cycle
        if (step != 2'd0) begin
          ok                  <= ok && vtx_in && rd_q.keep;
          remap_q[step - 2'd1] <= rd_q.remap;
        end else begin
          ok <= ok && vtx_in;
        end
        step <= step + 2'd1;
      end
      S_TLAST: begin
        remap_q[2] <= rd_q.remap;
      end
      default: ;
    endcase
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_ent;
    end
    rd_q <= mem[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (ld_out) begin
      out_valid_q <= 1'b1;
    end else if (result.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_q.kind <= kind_q;
      if (kind_q == KIND_TRI) begin
        out_q.out_x        <= '0;
        out_q.out_y        <= '0;
        out_q.out_z        <= '0;
        out_q.new_index    <= '0;
        out_q.out_vertex_a <= remap_q[0];
        out_q.out_vertex_b <= remap_q[1];
        out_q.out_vertex_c <= remap_q[2];
      end else begin
        out_q.out_x        <= item_q.point_x;
        out_q.out_y        <= item_q.point_y;
        out_q.out_z        <= item_q.point_z;
        out_q.new_index    <= new_idx_q;
        out_q.out_vertex_a <= '0;
        out_q.out_vertex_b <= '0;
        out_q.out_vertex_c <= '0;
      end
    end
  end

  assign result.valid = out_valid_q;
  assign result.data  = out_q;

`ifndef NO_ASSERTIONS
  // kept count never runs ahead of loaded count
  a_kept_le_loaded: assert property (@(posedge clk) disable iff (rst)
    points_kept <= points_loaded)
    else $error("points_kept above points_loaded");

  // a store write only happens with room left
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !store_full)
    else $error("store write while full");

  // result register is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ld_out |-> (!out_valid_q || result.ready))
    else $error("result overwritten before taken");

  // a loaded point bumps the load count by one
  a_load_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_PWR) |=> (points_loaded == $past(points_loaded) + 1'b1))
    else $error("load count did not advance");
`endif

endmodule
